// ===== design/pes_pkg.sv =====
// Shared constants and helpers for the packed 17-bit 3D element store.
package pes_pkg;

  localparam int PES_MAX_ELEMENTS = 4096;
  localparam int ELEM_W           = 17;
  localparam int WORD_W           = 16;
  localparam int DIM_W            = 5;
  localparam int COORD_W          = 4;
  localparam int IDX_W            = 16;
  localparam int DIM_MAX          = 16;

  localparam logic [DIM_W-1:0]  DIM_RESET = 5'd16;
  localparam logic [ELEM_W-1:0] ELEM_MAX  = 17'h1FFFF;

  // Operation codes carried on in_tuser.
  localparam logic [2:0] KIND_READ  = 3'd0;
  localparam logic [2:0] KIND_WRITE = 3'd1;
  localparam logic [2:0] KIND_ADD   = 3'd2;
  localparam logic [2:0] KIND_SUB   = 3'd3;
  localparam logic [2:0] KIND_SCALE = 3'd4;

  // Result status codes carried on out_tuser.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVF   = 2'd1;
  localparam logic [1:0] ST_UNF   = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DIM_LENGTH = 2'd0;
  localparam logic [1:0] CFG_DIM_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_DIM_HEIGHT = 2'd2;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    r = d;
    if (int'(d) > DIM_MAX) r = DIM_W'(DIM_MAX);
    return r;
  endfunction

endpackage

// ===== design/packed_17bit_3d_element_store.sv =====
// Top level: packed 17-bit element store with a shared multiplier and a small sequencer.
//
// Input beats (in_*) carry one operation on one element: kind on in_tuser, coordinates,
// operand and signed multiplier on in_tdata. Each beat yields exactly one result beat
// (out_*): the element value on out_tdata and a status code on out_tuser.
// Elements live back to back in 16-bit RAM words; each element spans two words, so an
// operation reads both words, merges and writes both back through one RAM port pair.
// One 18x16 signed multiplier serves the index math (two products) and the scale op.
// A coordinate out of range sends an item from S_MUL1 to S_DONE, an index beyond the
// store from S_RDLO, a read or failed check from S_CHK; a write-back adds S_WRLO/S_WRHI.
// in_tready rises at the edge that registers the result, so no new item is taken until
// the last is done; the RAM word pair and the shared multiplier set the steps of each.
// The result register lets the next item start while a result waits; if the receiver
// stalls, a finished item holds in its last step until out_tready frees the register.
// After reset the block clears the RAM, one word a cycle, all PACKED_WORDS words
// (4353 at the default size); in_tready stays low meanwhile. cfg writes are taken at
// any time and should only be issued while the block is idle.
module packed_17bit_3d_element_store import pes_pkg::*; #(
  parameter int MAX_ELEMENTS = PES_MAX_ELEMENTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // x_coord[3:0], y_coord[7:4], z_coord[11:8],
                                  // operand[28:12], multiplier[44:29], zero pad
  input  logic [2:0]  in_tuser,   // kind[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // element_value[16:0], zero pad
  output logic [1:0]  out_tuser,  // status[1:0]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [4:0]  cfg_wdata
);

  localparam int PACKED_WORDS = (MAX_ELEMENTS * ELEM_W + 15) / 16 + 1;
  localparam int AW           = $clog2(PACKED_WORDS);
  localparam int BIT_W        = $clog2(MAX_ELEMENTS * ELEM_W);

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_MUL1  = 13'b0000000000100,
    S_MUL2  = 13'b0000000001000,
    S_IDX   = 13'b0000000010000,
    S_RDLO  = 13'b0000000100000,
    S_RDHI  = 13'b0000001000000,
    S_EXT   = 13'b0000010000000,
    S_OP    = 13'b0000100000000,
    S_CHK   = 13'b0001000000000,
    S_WRLO  = 13'b0010000000000,
    S_WRHI  = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [DIM_W-1:0]   dim_len_r, dim_wid_r, dim_hgt_r;
  logic [DIM_W-1:0]   l_c, w_c, h_c;
  logic [AW-1:0]      clr_r;

  logic [2:0]         kind_r;
  logic [COORD_W-1:0] x_r, y_r, z_r;
  logic [ELEM_W-1:0]  opnd_r;
  logic signed [15:0] mult_r;

  logic [31:0]        prod_r;
  logic [IDX_W-1:0]   idx_r;
  logic [WORD_W-1:0]  lo_r, hi_r;
  logic [ELEM_W-1:0]  cur_r;
  logic [ELEM_W-1:0]  res_val_r;
  logic [1:0]         res_st_r;

  logic               out_valid_r;
  logic [ELEM_W-1:0]  out_val_r;
  logic [1:0]         out_st_r;

  logic signed [17:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [33:0] mul_p;

  logic [BIT_W-1:0]   bit_idx;
  logic [AW-1:0]      wa, wa1;
  logic [3:0]         sh;
  logic [31:0]        pair_new;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [WORD_W-1:0]  ram_wdata, ram_rdata;

  logic [ELEM_W:0]    sum;
  logic [ELEM_W-1:0]  chk_val;
  logic [1:0]         chk_st;
  logic               chk_wr;
  logic               coord_bad;
  logic               res_load;

  assign l_c = clamp_dim(dim_len_r);
  assign w_c = clamp_dim(dim_wid_r);
  assign h_c = clamp_dim(dim_hgt_r);

  assign coord_bad = ({1'b0, x_r} >= l_c) || ({1'b0, y_r} >= w_c) || ({1'b0, z_r} >= h_c);

  // Word address and bit offset of the element: bit = idx*17.
  assign bit_idx = BIT_W'({idx_r, 4'b0000}) + BIT_W'(idx_r);
  assign wa      = AW'(bit_idx[BIT_W-1:4]);
  assign wa1     = wa + 1'b1;
  assign sh      = bit_idx[3:0];

  assign pair_new = ({hi_r, lo_r} & ~(32'(ELEM_MAX) << sh)) | (32'(res_val_r) << sh);

  // Shared multiplier: index products, then the scale product.
  always_comb begin
    mul_a = signed'({1'b0, cur_r});
    mul_b = mult_r;
    case (state_r)
      S_MUL1: begin
        mul_a = signed'(18'(x_r));
        mul_b = signed'(16'(w_c));
      end
      S_MUL2: begin
        mul_a = signed'(18'(prod_r[15:0]) + 18'(y_r));
        mul_b = signed'(16'(h_c));
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  always_comb begin
    sum     = {1'b0, cur_r} + {1'b0, opnd_r};
    chk_val = cur_r;
    chk_st  = ST_OK;
    chk_wr  = 1'b0;
    case (kind_r)
      KIND_WRITE: begin
        chk_val = opnd_r;
        chk_wr  = 1'b1;
      end
      KIND_ADD: begin
        if (sum[ELEM_W]) chk_st = ST_OVF;
        else begin
          chk_val = sum[ELEM_W-1:0];
          chk_wr  = 1'b1;
        end
      end
      KIND_SUB: begin
        if (cur_r < opnd_r) chk_st = ST_UNF;
        else begin
          chk_val = cur_r - opnd_r;
          chk_wr  = 1'b1;
        end
      end
      KIND_SCALE: begin
        if (|prod_r[31:ELEM_W]) chk_st = ST_OVF;
        else begin
          chk_val = prod_r[ELEM_W-1:0];
          chk_wr  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign res_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == AW'(PACKED_WORDS - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_tvalid) state_nxt = S_MUL1;
      S_MUL1:  state_nxt = coord_bad ? S_DONE : S_MUL2;
      S_MUL2:  state_nxt = S_IDX;
      S_IDX:   state_nxt = S_RDLO;
      S_RDLO:  state_nxt = (int'(idx_r) >= MAX_ELEMENTS) ? S_DONE : S_RDHI;
      S_RDHI:  state_nxt = S_EXT;
      S_EXT:   state_nxt = S_OP;
      S_OP:    state_nxt = S_CHK;
      S_CHK:   state_nxt = chk_wr ? S_WRLO : S_DONE;
      S_WRLO:  state_nxt = S_WRHI;
      S_WRHI:  state_nxt = S_DONE;
      S_DONE:  if (res_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      dim_len_r   <= DIM_RESET;
      dim_wid_r   <= DIM_RESET;
      dim_hgt_r   <= DIM_RESET;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (res_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_DIM_LENGTH: dim_len_r <= cfg_wdata;
          CFG_DIM_WIDTH:  dim_wid_r <= cfg_wdata;
          CFG_DIM_HEIGHT: dim_hgt_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        kind_r <= in_tuser;
        x_r    <= in_tdata[3:0];
        y_r    <= in_tdata[7:4];
        z_r    <= in_tdata[11:8];
        opnd_r <= in_tdata[28:12];
        mult_r <= signed'(in_tdata[44:29]);
      end
      S_MUL1: begin
        prod_r    <= mul_p[31:0];
        res_val_r <= '0;
        res_st_r  <= ST_RANGE;
      end
      S_MUL2: prod_r <= mul_p[31:0];
      S_IDX:  idx_r  <= prod_r[IDX_W-1:0] + IDX_W'(z_r);
      S_RDLO: begin
        res_val_r <= '0;
        res_st_r  <= ST_RANGE;
      end
      S_RDHI: lo_r <= ram_rdata;
      S_EXT: begin
        hi_r  <= ram_rdata;
        cur_r <= ELEM_W'({ram_rdata, lo_r} >> sh);
      end
      S_OP:   prod_r <= mul_p[31:0];
      S_CHK: begin
        res_val_r <= chk_val;
        res_st_r  <= chk_st;
      end
      default: ;
    endcase
    if (res_load) begin
      out_val_r <= res_val_r;
      out_st_r  <= res_st_r;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wa;
    ram_wdata = pair_new[15:0];
    ram_raddr = (state_r == S_RDHI) ? wa1 : wa;
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
      end
      S_WRLO: ram_we = 1'b1;
      S_WRHI: begin
        ram_we    = 1'b1;
        ram_waddr = wa1;
        ram_wdata = pair_new[31:16];
      end
      default: ;
    endcase
  end

  pes_ram #(
    .WIDTH (WORD_W),
    .DEPTH (PACKED_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_val_r};
  assign out_tuser  = out_st_r;

endmodule

// ===== design/pes_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pes_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4353
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== test/pes_checker.sv =====
// Result checker for the packed 17-bit element store: mirrors the store and scores each beat.
`timescale 1ns / 100ps

module pes_checker import pes_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [4:0]  cfg_wdata,
  output int          mism_cnt,
  output int          pend_cnt,
  output int          ok_cnt,
  output int          ovf_cnt,
  output int          unf_cnt,
  output int          rng_cnt
);

  typedef struct packed {
    logic [ELEM_W-1:0] value;
    logic [1:0]        status;
  } elem_result_t;

  logic [ELEM_W-1:0] elem_mem [PES_MAX_ELEMENTS];
  logic [DIM_W-1:0]  dim_len, dim_wid, dim_hgt;
  elem_result_t      expected_q [$];

  function automatic int eff_dim(input logic [DIM_W-1:0] d);
    return (int'(d) > DIM_MAX) ? DIM_MAX : int'(d);
  endfunction

  // Apply one operation to the mirrored store and return the result it should produce.
  function automatic elem_result_t apply_elem_op(input logic [2:0] kind,
      input logic [3:0] x, input logic [3:0] y, input logic [3:0] z,
      input logic [ELEM_W-1:0] opnd, input logic [15:0] mult);
    elem_result_t      res;
    int                ext_l, ext_w, ext_h, idx;
    logic [ELEM_W:0]   sum;
    logic [31:0]       m32, prod;
    logic [ELEM_W-1:0] cur;
    ext_l = eff_dim(dim_len);
    ext_w = eff_dim(dim_wid);
    ext_h = eff_dim(dim_hgt);
    res.value  = '0;
    res.status = ST_RANGE;
    if (int'(x) >= ext_l || int'(y) >= ext_w || int'(z) >= ext_h) return res;
    idx = int'(x) * ext_w * ext_h + int'(y) * ext_h + int'(z);
    if (idx >= PES_MAX_ELEMENTS) return res;
    cur = elem_mem[idx];
    res.status = ST_OK;
    case (kind)
      KIND_WRITE: begin
        cur = opnd;
        elem_mem[idx] = cur;
      end
      KIND_ADD: begin
        sum = {1'b0, cur} + {1'b0, opnd};
        if (sum > ELEM_MAX) res.status = ST_OVF;
        else begin
          cur = sum[ELEM_W-1:0];
          elem_mem[idx] = cur;
        end
      end
      KIND_SUB: begin
        if (cur < opnd) res.status = ST_UNF;
        else begin
          cur = cur - opnd;
          elem_mem[idx] = cur;
        end
      end
      KIND_SCALE: begin
        // unsigned 32-bit product against the sign-extended factor
        m32  = {{16{mult[15]}}, mult};
        prod = {15'd0, cur} * m32;
        if (prod > ELEM_MAX) res.status = ST_OVF;
        else begin
          cur = prod[ELEM_W-1:0];
          elem_mem[idx] = cur;
        end
      end
      default: ;  // read, and spare codes act as a read
    endcase
    res.value = cur;
    return res;
  endfunction

  always @(posedge clk) begin
    elem_result_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < PES_MAX_ELEMENTS; i++) elem_mem[i] = '0;
      dim_len = DIM_RESET;
      dim_wid = DIM_RESET;
      dim_hgt = DIM_RESET;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_DIM_LENGTH: dim_len = cfg_wdata;
          CFG_DIM_WIDTH:  dim_wid = cfg_wdata;
          CFG_DIM_HEIGHT: dim_hgt = cfg_wdata;
          default: ;
        endcase
      end
      // score the result beat before queuing a new prediction
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          mism_cnt++;
          $display("%0t: result beat with nothing expected: value %0d status %0d",
                   $realtime, out_tdata[ELEM_W-1:0], out_tuser);
        end else begin
          exp_r = expected_q.pop_front();
          if (out_tdata[ELEM_W-1:0] !== exp_r.value || out_tuser !== exp_r.status) begin
            mism_cnt++;
            $display("%0t: mismatch: expected value %0d status %0d, got value %0d status %0d",
                     $realtime, exp_r.value, exp_r.status, out_tdata[ELEM_W-1:0], out_tuser);
          end
          case (exp_r.status)
            ST_OK:   ok_cnt++;
            ST_OVF:  ovf_cnt++;
            ST_UNF:  unf_cnt++;
            default: rng_cnt++;
          endcase
        end
      end
      if (in_tvalid && in_tready) begin
        expected_q.push_back(apply_elem_op(in_tuser, in_tdata[3:0], in_tdata[7:4],
                                           in_tdata[11:8], in_tdata[28:12], in_tdata[44:29]));
      end
    end
    pend_cnt = expected_q.size();
  end

endmodule

// ===== test/tb.sv =====
// Testbench top for the packed 17-bit element store: stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb;
  import pes_pkg::*;

  // unused operation codes, decoded as a read
  localparam logic [2:0] KIND_SPARE_LO  = 3'd5;
  localparam logic [2:0] KIND_SPARE_MID = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI  = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [4:0]  cfg_wdata = '0;

  int mism_cnt, pend_cnt, ok_cnt, ovf_cnt, unf_cnt, rng_cnt;
  int src_gap = 6;
  int dst_gap = 77;
  int sent_cnt = 0;
  int ext_l = DIM_MAX;
  int ext_w = DIM_MAX;
  int ext_h = DIM_MAX;

  always #1 clk = ~clk;

  packed_17bit_3d_element_store i_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_we, .cfg_addr, .cfg_wdata
  );

  pes_checker i_checker (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_we, .cfg_addr, .cfg_wdata,
    .mism_cnt, .pend_cnt, .ok_cnt, .ovf_cnt, .unf_cnt, .rng_cnt
  );

  always @(negedge clk) out_tready <= ($urandom_range(99) >= dst_gap);

  task automatic send_op(input logic [2:0] kind, input logic [3:0] x, input logic [3:0] y,
                         input logic [3:0] z, input logic [16:0] opnd, input logic [15:0] mult);
    @(negedge clk);
    while ($urandom_range(99) < src_gap) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, mult, opnd, z, y, x};
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    sent_cnt++;
  endtask

  // drain all results, then hold off so no write-back is still in flight
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pend_cnt != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic set_dims(input logic [4:0] l, input logic [4:0] w, input logic [4:0] h);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_DIM_LENGTH;
    cfg_wdata <= l;
    @(negedge clk);
    cfg_addr  <= CFG_DIM_WIDTH;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_addr  <= CFG_DIM_HEIGHT;
    cfg_wdata <= h;
    @(negedge clk);
    cfg_we    <= 1'b0;
    ext_l = (l > DIM_MAX) ? DIM_MAX : l;
    ext_w = (w > DIM_MAX) ? DIM_MAX : w;
    ext_h = (h > DIM_MAX) ? DIM_MAX : h;
  endtask

  // mostly in range, often on a few hot elements so add and subtract pile up
  function automatic logic [3:0] pick_coord(input int ext, input bit hot);
    if (ext == 0 || $urandom_range(9) == 0) return 4'($urandom_range(15));
    if (hot) return 4'($urandom_range((ext > 2) ? 1 : ext - 1));
    return 4'($urandom_range(ext - 1));
  endfunction

  task automatic run_random(input int n);
    bit          hot;
    logic [2:0]  kind;
    logic [3:0]  x, y, z;
    logic [16:0] opnd;
    logic [15:0] mult;
    for (int i = 0; i < n; i++) begin
      hot = 1'($urandom_range(1));
      x = pick_coord(ext_l, hot);
      y = pick_coord(ext_w, hot);
      z = pick_coord(ext_h, hot);
      kind = ($urandom_range(99) < 8) ? 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI))
                                      : 3'($urandom_range(KIND_SCALE));
      case ($urandom_range(3))
        0: opnd = 17'($urandom_range(255));
        1: opnd = 17'($urandom);
        2: opnd = ($urandom_range(1)) ? ELEM_MAX : 17'h10000;
        default: opnd = ELEM_MAX - 17'($urandom_range(255));
      endcase
      case ($urandom_range(3))
        0: mult = 16'($urandom_range(3));
        1: mult = 16'($urandom);
        2: mult = ($urandom_range(1)) ? 16'hFFFF : 16'h8000;
        default: mult = -16'($urandom_range(1, 4));
      endcase
      send_op(kind, x, y, z, opnd, mult);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // sender rarely idles, receiver mostly stalls; reset dimensions 16x16x16
    src_gap = 6;
    dst_gap = 77;
    send_op(KIND_READ,  4'd0,  4'd0,  4'd0,  17'd0,      16'd0);
    send_op(KIND_WRITE, 4'd0,  4'd0,  4'd0,  ELEM_MAX,   16'd0);
    send_op(KIND_WRITE, 4'd0,  4'd0,  4'd1,  17'h15555,  16'd0);
    send_op(KIND_READ,  4'd0,  4'd0,  4'd0,  17'd0,      16'd0);
    send_op(KIND_ADD,   4'd0,  4'd0,  4'd0,  17'd1,      16'd0);
    send_op(KIND_SUB,   4'd0,  4'd0,  4'd0,  ELEM_MAX,   16'd0);
    send_op(KIND_SUB,   4'd0,  4'd0,  4'd0,  17'd1,      16'd0);
    send_op(KIND_WRITE, 4'd15, 4'd15, 4'd15, 17'd100000, 16'd0);
    send_op(KIND_ADD,   4'd15, 4'd15, 4'd15, 17'd31071,  16'd0);
    send_op(KIND_ADD,   4'd15, 4'd15, 4'd15, 17'd0,      16'd0);
    send_op(KIND_WRITE, 4'd7,  4'd8,  4'd9,  17'd3,      16'd0);
    send_op(KIND_SCALE, 4'd7,  4'd8,  4'd9,  17'd0,      16'h7FFF);
    send_op(KIND_SCALE, 4'd7,  4'd8,  4'd9,  17'd0,      16'd2);
    send_op(KIND_WRITE, 4'd7,  4'd8,  4'd9,  17'd5,      16'd0);
    send_op(KIND_SCALE, 4'd7,  4'd8,  4'd9,  17'd0,      16'hFFFF);
    send_op(KIND_SCALE, 4'd0,  4'd0,  4'd0,  17'd0,      16'h8000);
    send_op(KIND_SCALE, 4'd7,  4'd8,  4'd9,  17'd0,      16'd1);
    send_op(KIND_SCALE, 4'd7,  4'd8,  4'd9,  17'd0,      16'd0);
    send_op(KIND_SPARE_LO,  4'd0,  4'd0,  4'd1,  ELEM_MAX, 16'hFFFF);
    send_op(KIND_SPARE_MID, 4'd15, 4'd15, 4'd15, 17'd1,    16'd1);
    send_op(KIND_SPARE_HI,  4'd15, 4'd0,  4'd15, 17'd7,    16'h8000);
    run_random(500);

    // zero length: everything out of range; oversized width clamps
    settle();
    set_dims(5'd0, 5'd31, 5'd5);
    send_op(KIND_WRITE, 4'd0, 4'd0, 4'd0, 17'd9, 16'd0);
    send_op(KIND_READ,  4'd0, 4'd15, 4'd4, 17'd0, 16'd0);
    run_random(40);

    // single element store; every other coordinate is out of range
    settle();
    set_dims(5'd1, 5'd1, 5'd1);
    send_op(KIND_WRITE, 4'd0, 4'd0, 4'd0, 17'd42, 16'd0);
    send_op(KIND_READ,  4'd1, 4'd0, 4'd0, 17'd0,  16'd0);
    send_op(KIND_READ,  4'd0, 4'd1, 4'd0, 17'd0,  16'd0);
    send_op(KIND_ADD,   4'd0, 4'd0, 4'd1, 17'd1,  16'd0);
    run_random(40);

    // sender mostly idles, receiver rarely stalls; assorted shapes
    src_gap = 77;
    dst_gap = 6;
    for (int p = 0; p < 3; p++) begin
      settle();
      set_dims(5'($urandom_range(1, 31)), 5'($urandom_range(1, 31)), 5'($urandom_range(1, 31)));
      run_random(220);
    end

    // no idling on either side
    src_gap = 0;
    dst_gap = 0;
    settle();
    set_dims(5'd31, 5'd31, 5'd31);
    run_random(350);
    settle();
    set_dims(5'd16, 5'd2, 5'd16);
    run_random(350);

    settle();
    $display("covered %0d operations over several store shapes and idle mixes;", sent_cnt);
    $display("results: %0d ok, %0d overflow, %0d underflow, %0d out of range",
             ok_cnt, ovf_cnt, unf_cnt, rng_cnt);
    if (mism_cnt == 0 && pend_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
